// ----- hdl/assert_macros.svh -----
// Assertion macros for files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pcs_pkg.sv -----
// Shared constants and controller/datapath interface types of the primality sorter.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_BATCH  = 65536;

    // Port fields are fixed at 32 bits, so only the low bits up to that width exist.
    localparam int N_BITS      = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int PORT_BITS   = 32;
    localparam int SLOT_BITS   = 16;
    localparam int D_BITS      = (N_BITS + 1) / 2 + 2;
    localparam int SQ_BITS     = 2 * D_BITS;
    localparam int REM_SH_BITS = D_BITS + 1;
    localparam int BIT_BITS    = $clog2(N_BITS);

    localparam int SLOT_LIMIT_INT = ((MAX_BATCH - 1) > 65535) ? 65535 : (MAX_BATCH - 1);
    localparam logic [SLOT_BITS-1:0] SLOT_LIMIT = SLOT_BITS'(SLOT_LIMIT_INT);

    localparam logic [D_BITS-1:0]  FIRST_ODD_DIV = D_BITS'(3);
    localparam logic [SQ_BITS-1:0] FIRST_ODD_SQ  = SQ_BITS'(9);

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic advance;
        logic set_verdict;
        logic verdict;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic n_lt2;
        logic n_even;
        logic n_is_two;
        logic sq_gt_n;
        logic bit_last;
        logic rem_zero;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/prime_composite_sorter_core.sv -----
// Top level of the trial-division primality sorter with per-batch slot counters.
// Values below 2 and even values go from the check state straight to the write state; a new
// request is accepted only in idle. An odd value n runs one division for each odd divisor d
// with d*d <= n, each over all N_BITS dividend bits in the bit-serial remainder unit (one
// dividend bit per cycle). A new request is taken while a result waits.
// Synchronous active-low reset clears the controller, the output valid and both slot counters.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prime_composite_sorter_core import pcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PORT_BITS-1:0] i_value,
    input  logic                 i_last_of_batch,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PORT_BITS-1:0] o_value_out,
    output logic                 o_is_prime,
    output logic [SLOT_BITS-1:0] o_slot
);

    t_cmd    cmd;
    t_status status;
    logic    busy;

    pcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pcs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_value         (i_value),
        .i_last_of_batch (i_last_of_batch),
        .i_stall         (i_stall),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_value_out     (o_value_out),
        .o_is_prime      (o_is_prime),
        .o_slot          (o_slot)
    );

    assign o_stall = busy;

    `ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "idle after accepted request")
    `ASSERT_SAME(a_write_needs_room, cmd.write, !o_valid || !i_stall, "result overwritten")
    `ASSERT_SAME(a_slot_in_range, o_valid, o_slot <= SLOT_LIMIT, "slot beyond limit")

endmodule

// ----- hdl/pcs_ctrl.sv -----
// Controller state machine that sequences the trial divisions for one request.
`timescale 1ns / 1ps

module pcs_ctrl import pcs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_NEXT  = 5'b01000,
        S_WRITE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.n_lt2) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                    n_state           = S_WRITE;
                end else if (i_status.n_even) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = i_status.n_is_two;
                    n_state           = S_WRITE;
                end else if (i_status.sq_gt_n) begin
                    // No odd divisor up to the square root divides the value.
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b1;
                    n_state           = S_WRITE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.rem_zero) begin
                    o_cmd.set_verdict = 1'b1;
                    o_cmd.verdict     = 1'b0;
                    n_state           = S_WRITE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- hdl/pcs_datapath.sv -----
// Datapath: value and divisor registers, serial remainder unit, slot counters, output register.
`timescale 1ns / 1ps

module pcs_datapath import pcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [PORT_BITS-1:0] i_value,
    input  logic                 i_last_of_batch,
    input  logic                 i_stall,
    output t_status              o_status,
    output logic                 o_valid,
    output logic [PORT_BITS-1:0] o_value_out,
    output logic                 o_is_prime,
    output logic [SLOT_BITS-1:0] o_slot
);

    logic [N_BITS-1:0]      r_n;
    logic                   r_last;
    logic [D_BITS-1:0]      r_d;
    logic [SQ_BITS-1:0]     r_sq;
    logic [D_BITS-1:0]      r_rem;
    logic [BIT_BITS-1:0]    r_bit;
    logic                   r_prime;
    logic [SLOT_BITS-1:0]   r_prime_slots;
    logic [SLOT_BITS-1:0]   r_comp_slots;
    logic                   r_out_valid;
    logic [PORT_BITS-1:0]   r_value_out;
    logic                   r_is_prime;
    logic [SLOT_BITS-1:0]   r_slot;

    logic [REM_SH_BITS-1:0] n_rem_sh;
    logic [REM_SH_BITS-1:0] n_rem_sub;
    logic [D_BITS-1:0]      n_rem;
    logic [SLOT_BITS-1:0]   n_slot;
    logic                   n_out_free;

    // One restoring step: bring in the next dividend bit, subtract when it fits.
    always_comb begin
        n_rem_sh  = {r_rem, r_n[r_bit]};
        n_rem_sub = n_rem_sh - REM_SH_BITS'(r_d);
        if (n_rem_sh >= REM_SH_BITS'(r_d)) begin
            n_rem = n_rem_sub[D_BITS-1:0];
        end else begin
            n_rem = n_rem_sh[D_BITS-1:0];
        end
    end

    assign n_slot     = r_prime ? r_prime_slots : r_comp_slots;
    assign n_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= i_value[N_BITS-1:0];
            r_last <= i_last_of_batch;
            r_d    <= FIRST_ODD_DIV;
            r_sq   <= FIRST_ODD_SQ;
        end else if (i_cmd.advance) begin
            // (d + 2)^2 = d^2 + 4d + 4
            r_sq <= r_sq + SQ_BITS'({r_d, 2'b00}) + SQ_BITS'(4);
            r_d  <= r_d + D_BITS'(2);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= BIT_BITS'(N_BITS - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_bit <= r_bit - BIT_BITS'(1);
        end
        if (i_cmd.set_verdict) begin
            r_prime <= i_cmd.verdict;
        end
        if (i_cmd.write) begin
            r_value_out <= PORT_BITS'(r_n);
            r_is_prime  <= r_prime;
            r_slot      <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_prime_slots <= '0;
            r_comp_slots  <= '0;
        end else begin
            if (i_cmd.write) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.write) begin
                if (r_last) begin
                    r_prime_slots <= '0;
                    r_comp_slots  <= '0;
                end else if (r_prime) begin
                    if (r_prime_slots < SLOT_LIMIT) begin
                        r_prime_slots <= r_prime_slots + SLOT_BITS'(1);
                    end
                end else begin
                    if (r_comp_slots < SLOT_LIMIT) begin
                        r_comp_slots <= r_comp_slots + SLOT_BITS'(1);
                    end
                end
            end
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.n_lt2    = (r_n < N_BITS'(2));
        o_status.n_even   = !r_n[0];
        o_status.n_is_two = (r_n == N_BITS'(2));
        o_status.sq_gt_n  = (r_sq > SQ_BITS'(r_n));
        o_status.bit_last = (r_bit == '0);
        o_status.rem_zero = (r_rem == '0);
        o_status.out_free = n_out_free;
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_value_out;
    assign o_is_prime  = r_is_prime;
    assign o_slot      = r_slot;

endmodule
